[rtl/time_code_pulse_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Time-code pulse decoder assertion macros
// Concurrent assertion helpers shared by the decoder RTL. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIME_CODE_PULSE_DECODER_DEFINES_SVH
`define TIME_CODE_PULSE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TCPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TCPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TCPD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TCPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/tcpd_pkg.sv]
// ----------------------------------------------------------------------------
// Time-code pulse decoder package
// Widths, frame layout, command and register codes, and the result type.
// ----------------------------------------------------------------------------
package tcpd_pkg;

   localparam int PULSE_WIDTH_W = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   localparam int FRAME_BITS    = 60;
   localparam int BIT_COUNT_W   = 6;

   // Frame layout, bit positions in order of arrival.
   localparam int POS_MIN    = 21;
   localparam int POS_P1     = 28;
   localparam int POS_HOUR   = 29;
   localparam int POS_P2     = 35;
   localparam int POS_DAY    = 36;
   localparam int POS_WDAY   = 42;
   localparam int POS_MONTH  = 45;
   localparam int POS_YEAR   = 50;
   localparam int POS_P3     = 58;
   localparam int GOOD_COUNT = 59;

   // Register reset values in timer ticks.
   localparam logic [CSR_DATA_W-1:0] ZERO_MIN_RST = 16'd1875;
   localparam logic [CSR_DATA_W-1:0] ZERO_MAX_RST = 16'd4531;
   localparam logic [CSR_DATA_W-1:0] ONE_MIN_RST  = 16'd4843;
   localparam logic [CSR_DATA_W-1:0] ONE_MAX_RST  = 16'd7656;

   localparam logic CMD_PULSE      = 1'b0;
   localparam logic CMD_MINUTE_GAP = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZERO_WIDTH_MIN = 2'd0,
      CSR_ZERO_WIDTH_MAX = 2'd1,
      CSR_ONE_WIDTH_MIN  = 2'd2,
      CSR_ONE_WIDTH_MAX  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       frame_ok;
      logic [6:0] minute;
      logic [5:0] hour;
      logic [5:0] day_of_month;
      logic [2:0] weekday;
      logic [4:0] month;
      logic [7:0] year_of_century;
   } frame_result_type;

endpackage

[rtl/tcpd_req_if.sv]
// ----------------------------------------------------------------------------
// Time-code pulse decoder request channel
// Valid/ready channel that carries one pulse or minute-gap item.
// ----------------------------------------------------------------------------
interface tcpd_req_if;
   import tcpd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [PULSE_WIDTH_W-1:0] pulse_width;

   modport source (output valid, output cmd, output pulse_width, input ready);
   modport sink   (input valid, input cmd, input pulse_width, output ready);
endinterface

[rtl/tcpd_rsp_if.sv]
// ----------------------------------------------------------------------------
// Time-code pulse decoder response channel
// Valid/ready channel that carries one decoded frame item.
// ----------------------------------------------------------------------------
interface tcpd_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_ok;
   logic [6:0] minute;
   logic [5:0] hour;
   logic [5:0] day_of_month;
   logic [2:0] weekday;
   logic [4:0] month;
   logic [7:0] year_of_century;

   modport source (
      output valid, output frame_ok, output minute, output hour,
      output day_of_month, output weekday, output month, output year_of_century,
      input ready
   );
   modport sink (
      input valid, input frame_ok, input minute, input hour,
      input day_of_month, input weekday, input month, input year_of_century,
      output ready
   );
endinterface

[rtl/time_code_pulse_decoder.sv]
// A minute-gap item is held in the input stage, and its result then in the result register.
// Throughput: one item per cycle; an item waits in the input stage only when it
// is a minute gap and the result register still holds an item not yet taken.
// The result register and the frame state update sit after one compare/decode.
// Reset (synchronous, active high) clears the frame, the bit count, both
// stages and restores the width bounds to their default values.
// ----------------------------------------------------------------------------
// Time-code pulse decoder
// Collects pulse-width bits into a 60-bit frame and reports the decoded
// date and time on each minute gap.
// ----------------------------------------------------------------------------
`include "time_code_pulse_decoder_defines.svh"

module time_code_pulse_decoder (
   input  logic                             clock,
   input  logic                             reset,
   tcpd_req_if.sink                         req_chan,
   tcpd_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [tcpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcpd_pkg::*;

   logic [CSR_DATA_W-1:0]    zero_min_ff, zero_min_in;
   logic [CSR_DATA_W-1:0]    zero_max_ff, zero_max_in;
   logic [CSR_DATA_W-1:0]    one_min_ff, one_min_in;
   logic [CSR_DATA_W-1:0]    one_max_ff, one_max_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_cmd_ff, s1_cmd_in;
   logic [PULSE_WIDTH_W-1:0] s1_width_ff, s1_width_in;

   logic [FRAME_BITS-1:0]    frame_bits_ff, frame_bits_in;
   logic [BIT_COUNT_W-1:0]   bit_count_ff, bit_count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   frame_result_type         rsp_result_ff, rsp_result_in;

   frame_result_type         eval_result;
   logic                     s1_go;
   logic                     s1_fire;
   logic                     gap_fire;
   logic                     is_zero;
   logic                     is_one;
   logic                     req_fire;

   tcpd_frame_eval u_eval (
      .frame_bits (frame_bits_ff),
      .bit_count  (bit_count_ff),
      .result     (eval_result)
   );

   // A minute gap needs the result register free or being emptied now.
   assign s1_go    = !(s1_cmd_ff == CMD_MINUTE_GAP && rsp_valid_ff && !rsp_chan.ready);
   assign s1_fire  = s1_valid_ff && s1_go;
   assign gap_fire = s1_fire && (s1_cmd_ff == CMD_MINUTE_GAP);

   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // The zero window wins where both windows overlap.
   assign is_zero = (zero_min_ff < s1_width_ff) && (s1_width_ff < zero_max_ff);
   assign is_one  = !is_zero && (one_min_ff < s1_width_ff) && (s1_width_ff < one_max_ff);

   always_comb begin
      zero_min_in = zero_min_ff;
      zero_max_in = zero_max_ff;
      one_min_in  = one_min_ff;
      one_max_in  = one_max_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ZERO_WIDTH_MIN: zero_min_in = csr_wdata;
            CSR_ZERO_WIDTH_MAX: zero_max_in = csr_wdata;
            CSR_ONE_WIDTH_MIN:  one_min_in  = csr_wdata;
            CSR_ONE_WIDTH_MAX:  one_max_in  = csr_wdata;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_width_in = s1_width_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = req_chan.cmd;
         s1_width_in = req_chan.pulse_width;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      frame_bits_in = frame_bits_ff;
      bit_count_in  = bit_count_ff;
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (gap_fire) begin
         rsp_result_in = eval_result;
         rsp_valid_in  = 1'b1;
         bit_count_in  = '0;
      end else if (s1_fire && (is_zero || is_one) &&
                   (bit_count_ff < BIT_COUNT_W'(FRAME_BITS))) begin
         frame_bits_in[bit_count_ff] = is_one;
         bit_count_in                = bit_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_min_ff   <= ZERO_MIN_RST;
         zero_max_ff   <= ZERO_MAX_RST;
         one_min_ff    <= ONE_MIN_RST;
         one_max_ff    <= ONE_MAX_RST;
         s1_valid_ff   <= 1'b0;
         frame_bits_ff <= '0;
         bit_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         zero_min_ff   <= zero_min_in;
         zero_max_ff   <= zero_max_in;
         one_min_ff    <= one_min_in;
         one_max_ff    <= one_max_in;
         s1_valid_ff   <= s1_valid_in;
         frame_bits_ff <= frame_bits_in;
         bit_count_ff  <= bit_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff     <= s1_cmd_in;
      s1_width_ff   <= s1_width_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.frame_ok        = rsp_result_ff.frame_ok;
   assign rsp_chan.minute          = rsp_result_ff.minute;
   assign rsp_chan.hour            = rsp_result_ff.hour;
   assign rsp_chan.day_of_month    = rsp_result_ff.day_of_month;
   assign rsp_chan.weekday         = rsp_result_ff.weekday;
   assign rsp_chan.month           = rsp_result_ff.month;
   assign rsp_chan.year_of_century = rsp_result_ff.year_of_century;

   `TCPD_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      bit_count_ff <= BIT_COUNT_W'(FRAME_BITS), "bit count passed the frame length")
   `TCPD_ASSERT_NEXT(a_gap_clears_count, clock, reset, gap_fire,
      bit_count_ff == '0 && rsp_valid_ff, "minute gap did not clear count or post item")
   `TCPD_ASSERT_NEXT(a_gap_held, clock, reset,
      s1_valid_ff && s1_cmd_ff == CMD_MINUTE_GAP && rsp_valid_ff && !rsp_chan.ready,
      s1_valid_ff && s1_cmd_ff == CMD_MINUTE_GAP, "blocked minute gap was dropped")
   `TCPD_ASSERT_IMP(a_bad_frame_zero, clock, reset,
      rsp_valid_ff && !rsp_result_ff.frame_ok,
      rsp_result_ff == '0, "bad frame item carries nonzero fields")

endmodule

[rtl/tcpd_frame_eval.sv]
// ----------------------------------------------------------------------------
// Time-code frame evaluation
// Checks bit count and the three even parities and decodes the BCD fields.
// ----------------------------------------------------------------------------
module tcpd_frame_eval (
   input  logic [tcpd_pkg::FRAME_BITS-1:0]  frame_bits,
   input  logic [tcpd_pkg::BIT_COUNT_W-1:0] bit_count,
   output tcpd_pkg::frame_result_type       result
);
   import tcpd_pkg::*;

   // Ones digit plus ten times the tens digit; the sum stays below 166.
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      return {4'b0000, b[3:0]} + {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
   endfunction

   logic       par_min_ok;
   logic       par_hour_ok;
   logic       par_date_ok;
   logic       frame_ok;
   logic [7:0] minute_sum;
   logic [7:0] hour_sum;
   logic [7:0] day_sum;
   logic [7:0] month_sum;
   logic [7:0] year_sum;

   assign par_min_ok  = (^frame_bits[POS_P1-1:POS_MIN])  == frame_bits[POS_P1];
   assign par_hour_ok = (^frame_bits[POS_P2-1:POS_HOUR]) == frame_bits[POS_P2];
   assign par_date_ok = (^frame_bits[POS_P3-1:POS_DAY])  == frame_bits[POS_P3];

   assign frame_ok = (bit_count == BIT_COUNT_W'(GOOD_COUNT)) &&
                     par_min_ok && par_hour_ok && par_date_ok;

   assign minute_sum = bcd_value({1'b0, frame_bits[POS_P1-1:POS_MIN]});
   assign hour_sum   = bcd_value({2'b00, frame_bits[POS_P2-1:POS_HOUR]});
   assign day_sum    = bcd_value({2'b00, frame_bits[POS_WDAY-1:POS_DAY]});
   assign month_sum  = bcd_value({3'b000, frame_bits[POS_YEAR-1:POS_MONTH]});
   assign year_sum   = bcd_value(frame_bits[POS_P3-1:POS_YEAR]);

   // A bad frame reports all fields as zero.
   always_comb begin
      result = '0;
      if (frame_ok) begin
         result.frame_ok        = 1'b1;
         result.minute          = minute_sum[6:0];
         result.hour            = hour_sum[5:0];
         result.day_of_month    = day_sum[5:0];
         result.weekday         = frame_bits[POS_MONTH-1:POS_WDAY];
         result.month           = month_sum[4:0];
         result.year_of_century = year_sum;
      end
   end

endmodule
